// File: sv/assert_macros.svh
// Assertion helpers for the checks in the top-level allocator module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that one condition implies another on the same edge.
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

// File: sv/bfra_pkg.sv
`default_nettype none
package bfra_pkg;

  localparam logic [31:0] CHUNK_RESET     = 32'd4096;
  localparam logic [31:0] MAX_TOTAL_RESET = 32'd1048576;
  localparam logic [31:0] TOP_END         = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CAP  = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_CHUNK     = 1'b0,
    REG_MAX_TOTAL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } range_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SEED, OP_COPY_INIT, OP_COPY_RD, OP_COPY_WR,
    OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_EV, OP_GROW, OP_TAKE_PREP,
    OP_RM_RD, OP_RM_WR, OP_RM_DONE, OP_LEAD_PREP, OP_TRAIL_PREP,
    OP_FREE_PREP, OP_INS_INIT, OP_INS_RD, OP_INS_EV, OP_MERGE2,
    OP_MERGE_PREV, OP_MERGE_NEXT, OP_SH_INIT, OP_SH_RD, OP_SH_WR,
    OP_INS_NEW, OP_FINISH, OP_SUM_INIT, OP_SUM_RD, OP_SUM_EV, OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    RET_GROW, RET_LEAD, RET_TRAIL, RET_FREE
  } ret_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SEED, S_CHECK, S_COPY_INIT, S_COPY_RD, S_COPY_WR, S_DISPATCH,
    S_SCAN_INIT, S_SCAN_RD, S_SCAN_EV, S_SCAN_END, S_TAKE_PREP,
    S_RM_RD, S_RM_WR, S_LEAD, S_TRAIL, S_INS_INIT, S_INS_RD, S_INS_EV,
    S_INS_DEC, S_RM2_RD, S_RM2_WR, S_SH_RD, S_SH_WR, S_INS_RET,
    S_FINISH, S_SUM_INIT, S_SUM_RD, S_SUM_EV, S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic seeded;
    logic req_zero;
    logic is_free;
    logic ptr_lt_w;
    logic ptr1_lt_w;
    logic ptr_lt_cur;
    logic q_gt_ptr;
    logic ins_go;
    logic prev_adj;
    logic next_adj;
    logic full;
    logic found;
    logic grow_over;
    logic lead;
    logic trail;
    logic out_free;
  } dp_status_t;

  // Bytes needed to move off up to the next multiple of 2^a.
  function automatic logic [31:0] pad_for(input logic [31:0] off, input logic [4:0] a);
    logic [31:0] mask;
    mask = (32'd1 << a) - 32'd1;
    return (~off + 32'd1) & mask;
  endfunction

endpackage
`default_nettype wire

// File: sv/bfra_ctrl.sv
`default_nettype none
module bfra_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  bfra_pkg::dp_status_t st,
  output bfra_pkg::dp_cmd_t    cmd
);
  import bfra_pkg::*;

  state_t  state, state_next;
  ret_t    ret, ret_next;
  logic    pass2, pass2_next;
  status_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_FREE;
      pass2 <= 1'b0;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      pass2 <= pass2_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    pass2_next = pass2;
    code_next  = code;
    cmd.op     = OP_NONE;
    cmd.code   = code;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = st.seeded ? S_CHECK : S_SEED;
        end
      end
      S_SEED: begin
        cmd.op     = OP_SEED;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.req_zero) begin
          code_next  = ST_ZERO;
          state_next = S_FINISH;
        end else begin
          state_next = S_COPY_INIT;
        end
      end
      S_COPY_INIT: begin
        cmd.op     = OP_COPY_INIT;
        state_next = S_COPY_RD;
      end
      S_COPY_RD: begin
        if (st.ptr_lt_w) begin
          cmd.op     = OP_COPY_RD;
          state_next = S_COPY_WR;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_COPY_WR: begin
        cmd.op     = OP_COPY_WR;
        state_next = S_COPY_RD;
      end
      S_DISPATCH: begin
        if (st.is_free) begin
          cmd.op     = OP_FREE_PREP;
          ret_next   = RET_FREE;
          state_next = S_INS_INIT;
        end else begin
          pass2_next = 1'b0;
          state_next = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.op     = OP_SCAN_INIT;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (st.ptr_lt_w) begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_SCAN_EV;
        end else begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_EV: begin
        cmd.op     = OP_SCAN_EV;
        state_next = S_SCAN_RD;
      end
      S_SCAN_END: begin
        if (st.found) begin
          state_next = S_TAKE_PREP;
        end else if (pass2 || st.grow_over) begin
          code_next  = ST_CAP;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_GROW;
          ret_next   = RET_GROW;
          state_next = S_INS_INIT;
        end
      end
      S_TAKE_PREP: begin
        cmd.op     = OP_TAKE_PREP;
        state_next = S_RM_RD;
      end
      S_RM_RD: begin
        if (st.ptr1_lt_w) begin
          cmd.op     = OP_RM_RD;
          state_next = S_RM_WR;
        end else begin
          cmd.op     = OP_RM_DONE;
          state_next = S_LEAD;
        end
      end
      S_RM_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = S_RM_RD;
      end
      S_LEAD: begin
        if (st.lead) begin
          cmd.op     = OP_LEAD_PREP;
          ret_next   = RET_LEAD;
          state_next = S_INS_INIT;
        end else begin
          state_next = S_TRAIL;
        end
      end
      S_TRAIL: begin
        if (st.trail) begin
          cmd.op     = OP_TRAIL_PREP;
          ret_next   = RET_TRAIL;
          state_next = S_INS_INIT;
        end else begin
          code_next  = ST_OK;
          state_next = S_FINISH;
        end
      end
      S_INS_INIT: begin
        cmd.op     = OP_INS_INIT;
        state_next = S_INS_RD;
      end
      S_INS_RD: begin
        if (st.ptr_lt_w) begin
          cmd.op     = OP_INS_RD;
          state_next = S_INS_EV;
        end else begin
          state_next = S_INS_DEC;
        end
      end
      S_INS_EV: begin
        cmd.op     = OP_INS_EV;
        state_next = st.ins_go ? S_INS_RD : S_INS_DEC;
      end
      S_INS_DEC: begin
        if (st.prev_adj && st.next_adj) begin
          cmd.op     = OP_MERGE2;
          state_next = S_RM2_RD;
        end else if (st.prev_adj) begin
          cmd.op     = OP_MERGE_PREV;
          state_next = S_INS_RET;
        end else if (st.next_adj) begin
          cmd.op     = OP_MERGE_NEXT;
          state_next = S_INS_RET;
        end else if (st.full) begin
          code_next  = ST_FULL;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_SH_INIT;
          state_next = S_SH_RD;
        end
      end
      S_RM2_RD: begin
        if (st.ptr1_lt_w) begin
          cmd.op     = OP_RM_RD;
          state_next = S_RM2_WR;
        end else begin
          cmd.op     = OP_RM_DONE;
          state_next = S_INS_RET;
        end
      end
      S_RM2_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = S_RM2_RD;
      end
      S_SH_RD: begin
        if (st.q_gt_ptr) begin
          cmd.op     = OP_SH_RD;
          state_next = S_SH_WR;
        end else begin
          cmd.op     = OP_INS_NEW;
          state_next = S_INS_RET;
        end
      end
      S_SH_WR: begin
        cmd.op     = OP_SH_WR;
        state_next = S_SH_RD;
      end
      S_INS_RET: begin
        case (ret)
          RET_GROW: begin
            pass2_next = 1'b1;
            state_next = S_SCAN_INIT;
          end
          RET_LEAD: begin
            state_next = S_TRAIL;
          end
          default: begin
            code_next  = ST_OK;
            state_next = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_SUM_INIT;
      end
      S_SUM_INIT: begin
        cmd.op     = OP_SUM_INIT;
        state_next = S_SUM_RD;
      end
      S_SUM_RD: begin
        if (st.ptr_lt_cur) begin
          cmd.op     = OP_SUM_RD;
          state_next = S_SUM_EV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SUM_EV: begin
        cmd.op     = OP_SUM_EV;
        state_next = S_SUM_RD;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/bfra_dp.sv
`default_nettype none
module bfra_dp #(
  parameter int MAX_RANGES = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  bfra_pkg::dp_cmd_t    cmd,
  output bfra_pkg::dp_status_t st,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [0:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  input  wire  [0:0]           command,
  input  wire  [31:0]          req_size,
  input  wire  [4:0]           align_log2,
  input  wire  [31:0]          free_offset,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           status,
  output logic [31:0]          alloc_offset,
  output logic [31:0]          free_bytes,
  output logic [31:0]          space_size
);
  import bfra_pkg::*;

  localparam int IW        = $clog2(MAX_RANGES);
  localparam int CW        = $clog2(MAX_RANGES + 1);
  localparam int AW        = IW + 1;
  localparam int MEM_DEPTH = 2 ** AW;

  // Two banks: the committed table and a working copy that an item edits.
  range_t mem [MEM_DEPTH];
  range_t rdata;
  logic   rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  range_t wr_data;

  logic [31:0] chunk_size, max_total_size;
  logic          cur_bank;
  logic [CW-1:0] cur_cnt;
  logic [31:0]   cur_base;
  logic          seeded;

  cmd_t        req_cmd;
  logic [31:0] req_sz, req_foff;
  logic [4:0]  req_align;

  logic [CW-1:0] ptr, q, w_cnt;
  logic [31:0]   w_base;
  logic          found;
  logic [31:0]   best_len, best_start;
  logic [CW-1:0] best_idx;
  logic [31:0]   take_s;
  logic [32:0]   take_e, take_o;
  logic [32:0]   ins_off, ins_len;
  logic          prev_valid, nxt_valid;
  logic [31:0]   prev_s, prev_l, nxt_s, nxt_l;
  logic [31:0]   sum;
  status_t       status_r;
  logic [31:0]   grant_r;

  logic [CW-1:0] ptr_p1, ptr_m1, q_m1;
  logic [32:0]   free_end;
  logic [31:0]   flen;
  logic [33:0]   need;
  logic          fits, better;
  logic [31:0]   g_pad;
  logic [33:0]   g_tot;
  logic [32:0]   g_step;
  logic [33:0]   g_nb34;
  logic [31:0]   g_nb;
  logic [33:0]   trail_off;
  logic [33:0]   ins_end;
  logic [32:0]   prev_end, nxt_end;
  logic [32:0]   sum_add;

  assign ptr_p1    = ptr + 1'b1;
  assign ptr_m1    = ptr - 1'b1;
  assign q_m1      = q - 1'b1;
  assign free_end  = {1'b0, req_foff} + {1'b0, req_sz};
  assign flen      = free_end[32] ? (TOP_END - req_foff) : req_sz;
  assign need      = 34'(req_sz) + 34'(pad_for(rdata.start, req_align));
  assign fits      = need <= 34'(rdata.length);
  assign better    = !found || (rdata.length <= best_len);
  assign g_pad     = pad_for(w_base, req_align);
  assign g_tot     = 34'(w_base) + 34'(req_sz) + 34'(g_pad);
  always_comb begin
    g_step = 33'(req_sz) + 33'(g_pad);
    if (33'(chunk_size) > g_step) begin
      g_step = 33'(chunk_size);
    end
  end
  assign g_nb34    = 34'(w_base) + 34'(g_step);
  assign g_nb      = (g_nb34 > 34'(max_total_size)) ? max_total_size : g_nb34[31:0];
  assign trail_off = 34'(take_o) + 34'(req_sz);
  assign ins_end   = 34'(ins_off) + 34'(ins_len);
  assign prev_end  = 33'(prev_s) + 33'(prev_l);
  assign nxt_end   = 33'(nxt_s) + 33'(nxt_l);
  assign sum_add   = 33'(sum) + 33'(rdata.length);

  always_comb begin
    st.seeded     = seeded;
    st.req_zero   = (req_cmd == CMD_FREE) ? (flen == 32'd0) : (req_sz == 32'd0);
    st.is_free    = (req_cmd == CMD_FREE);
    st.ptr_lt_w   = ptr < w_cnt;
    st.ptr1_lt_w  = ptr_p1 < w_cnt;
    st.ptr_lt_cur = ptr < cur_cnt;
    st.q_gt_ptr   = q > ptr;
    st.ins_go     = 33'(rdata.start) <= ins_off;
    st.prev_adj   = prev_valid && (prev_end == ins_off);
    st.next_adj   = nxt_valid && (ins_end == 34'(nxt_s));
    st.full       = w_cnt == CW'(MAX_RANGES);
    st.found      = found;
    st.grow_over  = g_tot > 34'(max_total_size);
    st.lead       = take_o > 33'(take_s);
    st.trail      = trail_off < 34'(take_e);
    st.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (cmd.op)
      OP_SEED: begin
        wr_en   = 1'b1;
        wr_addr = {cur_bank, {IW{1'b0}}};
        wr_data = '{start: 32'd0, length: chunk_size};
      end
      OP_COPY_RD: begin
        rd_en   = 1'b1;
        rd_addr = {cur_bank, ptr[IW-1:0]};
      end
      OP_COPY_WR: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr[IW-1:0]};
        wr_data = rdata;
      end
      OP_SCAN_RD, OP_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = {~cur_bank, ptr[IW-1:0]};
      end
      OP_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = {~cur_bank, ptr_p1[IW-1:0]};
      end
      OP_RM_WR: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr[IW-1:0]};
        wr_data = rdata;
      end
      OP_MERGE2: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr_m1[IW-1:0]};
        wr_data = '{start: prev_s, length: 32'(nxt_end - 33'(prev_s))};
      end
      OP_MERGE_PREV: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr_m1[IW-1:0]};
        wr_data = '{start: prev_s, length: 32'(ins_end - 34'(prev_s))};
      end
      OP_MERGE_NEXT: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr[IW-1:0]};
        wr_data = '{start: ins_off[31:0], length: 32'(nxt_end - ins_off)};
      end
      OP_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = {~cur_bank, q_m1[IW-1:0]};
      end
      OP_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, q[IW-1:0]};
        wr_data = rdata;
      end
      OP_INS_NEW: begin
        wr_en   = 1'b1;
        wr_addr = {~cur_bank, ptr[IW-1:0]};
        wr_data = '{start: ins_off[31:0], length: ins_len[31:0]};
      end
      OP_SUM_RD: begin
        rd_en   = 1'b1;
        rd_addr = {cur_bank, ptr[IW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size     <= CHUNK_RESET;
      max_total_size <= MAX_TOTAL_RESET;
      cur_bank       <= 1'b0;
      cur_cnt        <= '0;
      cur_base       <= '0;
      seeded         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHUNK:     chunk_size     <= cfg_data;
          REG_MAX_TOTAL: max_total_size <= cfg_data;
          default: begin
          end
        endcase
      end
      // A new result may replace one that transfers in the same cycle.
      if (cmd.op == OP_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_SEED: begin
          seeded   <= 1'b1;
          cur_base <= chunk_size;
          cur_cnt  <= (chunk_size != 32'd0) ? CW'(1) : '0;
        end
        OP_FINISH: begin
          // A successful item makes the working bank the committed one.
          if (cmd.code == ST_OK) begin
            cur_bank <= ~cur_bank;
            cur_cnt  <= w_cnt;
            cur_base <= w_base;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_cmd   <= cmd_t'(command);
        req_sz    <= req_size;
        req_align <= align_log2;
        req_foff  <= free_offset;
      end
      OP_COPY_INIT: begin
        ptr    <= '0;
        w_cnt  <= cur_cnt;
        w_base <= cur_base;
      end
      OP_COPY_WR, OP_RM_WR: begin
        ptr <= ptr_p1;
      end
      OP_SCAN_INIT: begin
        ptr   <= '0;
        found <= 1'b0;
      end
      OP_SCAN_EV: begin
        if (fits && better) begin
          found      <= 1'b1;
          best_len   <= rdata.length;
          best_start <= rdata.start;
          best_idx   <= ptr;
        end
        ptr <= ptr_p1;
      end
      OP_GROW: begin
        w_base  <= g_nb;
        ins_off <= 33'(w_base);
        ins_len <= 33'(g_nb - w_base);
      end
      OP_TAKE_PREP: begin
        take_s <= best_start;
        take_e <= 33'(best_start) + 33'(best_len);
        take_o <= 33'(best_start) + 33'(pad_for(best_start, req_align));
        ptr    <= best_idx;
      end
      OP_RM_DONE: begin
        w_cnt <= w_cnt - 1'b1;
      end
      OP_LEAD_PREP: begin
        ins_off <= 33'(take_s);
        ins_len <= take_o - 33'(take_s);
      end
      OP_TRAIL_PREP: begin
        ins_off <= trail_off[32:0];
        ins_len <= 33'(34'(take_e) - trail_off);
      end
      OP_FREE_PREP: begin
        ins_off <= 33'(req_foff);
        ins_len <= 33'(flen);
      end
      OP_INS_INIT: begin
        ptr        <= '0;
        prev_valid <= 1'b0;
        nxt_valid  <= 1'b0;
      end
      OP_INS_EV: begin
        if (33'(rdata.start) <= ins_off) begin
          prev_s     <= rdata.start;
          prev_l     <= rdata.length;
          prev_valid <= 1'b1;
          ptr        <= ptr_p1;
        end else begin
          nxt_s     <= rdata.start;
          nxt_l     <= rdata.length;
          nxt_valid <= 1'b1;
        end
      end
      OP_SH_INIT: begin
        q <= w_cnt;
      end
      OP_SH_WR: begin
        q <= q_m1;
      end
      OP_INS_NEW: begin
        w_cnt <= w_cnt + 1'b1;
      end
      OP_FINISH: begin
        status_r <= cmd.code;
        grant_r  <= (cmd.code == ST_OK && req_cmd == CMD_ALLOC) ? take_o[31:0] : 32'd0;
      end
      OP_SUM_INIT: begin
        ptr <= '0;
        sum <= '0;
      end
      OP_SUM_EV: begin
        sum <= sum_add[32] ? TOP_END : sum_add[31:0];
        ptr <= ptr_p1;
      end
      OP_LOAD_OUT: begin
        status       <= status_r;
        alloc_offset <= grant_r;
        free_bytes   <= sum;
        space_size   <= cur_base;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/best_fit_range_allocator.sv
// Best-fit allocator over a table of free ranges kept sorted by offset in a
// memory of two banks (committed table and working copy) with one read and
// one write port. Each command walks the table in passes, because the memory
// gives one registered read a cycle: a copy pass, one or two search passes, up
// to three insert passes with shifts, and a final pass that sums the free
// bytes. A zero-size command skips the copy and search but still sums the
// table. A result waits in an output register, so the next command can be
// taken while it is still pending. Configuration is accepted on any cycle.
`default_nettype none
module best_fit_range_allocator #(
  parameter int MAX_RANGES = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [0:0]  command,
  input  wire  [31:0] req_size,
  input  wire  [4:0]  align_log2,
  input  wire  [31:0] free_offset,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  status,
  output logic [31:0] alloc_offset,
  output logic [31:0] free_bytes,
  output logic [31:0] space_size
);
  import bfra_pkg::*;
  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t st;

  bfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bfra_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .req_size     (req_size),
    .align_log2   (align_log2),
    .free_offset  (free_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .alloc_offset (alloc_offset),
    .free_bytes   (free_bytes),
    .space_size   (space_size)
  );

  // A result is only loaded into a free output register.
  `ASSERT_IMPLY(a_load_free, clk, rst, cmd.op == OP_LOAD_OUT, st.out_free, "output overwritten")
  // A new entry is never appended to a full table.
  `ASSERT_IMPLY(a_ins_room, clk, rst, cmd.op == OP_INS_NEW, !st.full, "insert into full table")
  // A fresh result always comes from a load command.
  `ASSERT_CLK(a_out_src, clk, rst, $rose(out_valid) |-> $past(cmd.op == OP_LOAD_OUT), "spurious result")

endmodule
`default_nettype wire

// File: tb/best_fit_range_allocator_checker.sv
module best_fit_range_allocator_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [0:0]  command,
  input  wire  [31:0] req_size,
  input  wire  [4:0]  align_log2,
  input  wire  [31:0] free_offset,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [1:0]  status,
  input  wire  [31:0] alloc_offset,
  input  wire  [31:0] free_bytes,
  input  wire  [31:0] space_size,
  output int          fail_count,
  output int          pending
);
  import bfra_pkg::*;

  localparam int DEPTH = 32;

  typedef struct {
    logic [31:0] starts[DEPTH];
    logic [31:0] lens[DEPTH];
    int          count;
    logic [32:0] base;
  } free_table_t;

  typedef struct {
    status_t     st;
    logic [31:0] off;
    logic [31:0] bytes;
    logic [31:0] space;
  } grant_t;

  free_table_t committed;
  logic        is_seeded;
  logic [31:0] chunk_r, max_total_r;
  grant_t      grants_due[$];

  function automatic logic [32:0] align_pad(logic [32:0] off, logic [4:0] a);
    logic [32:0] mask;
    mask = (33'd1 << a) - 33'd1;
    return (33'd0 - off) & mask;
  endfunction

  function automatic void drop_entry(inout free_table_t t, input int i);
    for (int k = i; k < t.count - 1; k++) begin
      t.starts[k] = t.starts[k + 1];
      t.lens[k] = t.lens[k + 1];
    end
    t.count--;
  endfunction

  function automatic bit add_range(inout free_table_t t, input logic [32:0] off,
                                   input logic [32:0] len);
    int p;
    logic [32:0] e;
    bit pa, na;
    p = 0;
    e = off + len;
    while (p < t.count && {1'b0, t.starts[p]} <= off) p++;
    pa = p > 0 && ({1'b0, t.starts[p - 1]} + {1'b0, t.lens[p - 1]}) == off;
    na = p < t.count && e == {1'b0, t.starts[p]};
    if (pa && na) begin
      t.lens[p - 1] = 32'(t.starts[p] + t.lens[p] - t.starts[p - 1]);
      drop_entry(t, p);
    end else if (pa) begin
      t.lens[p - 1] = 32'(e - {1'b0, t.starts[p - 1]});
    end else if (na) begin
      t.lens[p] = 32'({1'b0, t.starts[p]} + {1'b0, t.lens[p]} - off);
      t.starts[p] = off[31:0];
    end else begin
      if (t.count >= DEPTH) return 0;
      for (int k = t.count; k > p; k--) begin
        t.starts[k] = t.starts[k - 1];
        t.lens[k] = t.lens[k - 1];
      end
      t.starts[p] = off[31:0];
      t.lens[p] = len[31:0];
      t.count++;
    end
    return 1;
  endfunction

  function automatic status_t best_fit_take(inout free_table_t t, input logic [32:0] size,
                                            input logic [4:0] a, output logic [31:0] got);
    logic [32:0] best, s, e, o;
    int idx;
    bit found;
    best = '1;
    idx = 0;
    found = 0;
    got = '0;
    for (int i = 0; i < t.count; i++) begin
      if (size + align_pad({1'b0, t.starts[i]}, a) > {1'b0, t.lens[i]} ||
          {1'b0, t.lens[i]} > best) continue;
      best = {1'b0, t.lens[i]};
      idx = i;
      found = 1;
    end
    if (!found) return ST_CAP;
    s = {1'b0, t.starts[idx]};
    e = s + {1'b0, t.lens[idx]};
    o = s + align_pad(s, a);
    drop_entry(t, idx);
    if (o > s && !add_range(t, s, o - s)) return ST_FULL;
    if (o + size < e && !add_range(t, o + size, e - (o + size))) return ST_FULL;
    got = o[31:0];
    return ST_OK;
  endfunction

  function automatic grant_t run_command(cmd_t cmd, logic [31:0] size, logic [4:0] a,
                                         logic [31:0] foff);
    grant_t g;
    free_table_t w;
    logic [32:0] old, p, stepv, nb, len;
    logic [33:0] sum;
    status_t r;
    g.off = '0;
    g.st = ST_OK;
    if (!is_seeded) begin
      is_seeded = 1;
      committed.count = 0;
      committed.base = {1'b0, chunk_r};
      if (chunk_r != 0) begin
        committed.starts[0] = '0;
        committed.lens[0] = chunk_r;
        committed.count = 1;
      end
    end
    w = committed;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        g.st = ST_ZERO;
      end else begin
        r = best_fit_take(w, {1'b0, size}, a, g.off);
        if (r == ST_CAP) begin
          old = w.base;
          p = align_pad(old, a);
          if (34'(old) + 34'(size) + 34'(p) <= 34'(max_total_r)) begin
            stepv = {1'b0, size} + p;
            if ({1'b0, chunk_r} > stepv) stepv = {1'b0, chunk_r};
            nb = old + stepv;
            if (nb > {1'b0, max_total_r}) nb = {1'b0, max_total_r};
            w.base = nb;
            if (!add_range(w, old, nb - old)) r = ST_FULL;
            else r = best_fit_take(w, {1'b0, size}, a, g.off);
          end
        end
        g.st = r;
        if (r == ST_OK) committed = w;
        else g.off = '0;
      end
    end else begin
      len = {1'b0, size};
      if ({1'b0, foff} + len > 33'h0FFFFFFFF) len = 33'h0FFFFFFFF - {1'b0, foff};
      if (len == 0) g.st = ST_ZERO;
      else if (!add_range(w, {1'b0, foff}, len)) g.st = ST_FULL;
      else committed = w;
    end
    sum = '0;
    for (int i = 0; i < committed.count; i++) sum += {2'b00, committed.lens[i]};
    g.bytes = sum > 34'h0FFFFFFFF ? 32'hFFFF_FFFF : sum[31:0];
    g.space = committed.base[31:0];
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      committed.count = 0;
      committed.base = '0;
      is_seeded = 0;
      chunk_r = CHUNK_RESET;
      max_total_r = MAX_TOTAL_RESET;
      fail_count = 0;
      grants_due = {};
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_CHUNK) chunk_r = cfg_data;
        else max_total_r = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          g = grants_due.pop_front();
          if (status != g.st) begin
            $error("status expected %0d actual %0d", g.st, status);
            fail_count++;
          end
          if (alloc_offset != g.off) begin
            $error("alloc_offset expected %0h actual %0h", g.off, alloc_offset);
            fail_count++;
          end
          if (free_bytes != g.bytes) begin
            $error("free_bytes expected %0h actual %0h", g.bytes, free_bytes);
            fail_count++;
          end
          if (space_size != g.space) begin
            $error("space_size expected %0h actual %0h", g.space, space_size);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        grants_due = {grants_due,
                      run_command(cmd_t'(command), req_size, align_log2, free_offset)};
    end
    pending = grants_due.size();
  end
endmodule

// File: tb/best_fit_range_allocator_tb.sv
module best_fit_range_allocator_tb;
  import bfra_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [0:0]  command = 0;
  logic [31:0] req_size = 0;
  logic [4:0]  align_log2 = 0;
  logic [31:0] free_offset = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [31:0] alloc_offset, free_bytes, space_size;
  int          fail_count, pending;

  bit          calm = 0;
  bit          hold_off = 0;
  int          idle_cycles = 0;
  logic [31:0] granted[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  best_fit_range_allocator u_dut (.*);
  best_fit_range_allocator_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
  end

  // Remember granted offsets so later frees return real ranges.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall && status == ST_OK && alloc_offset != 0)
      if (granted.size() < 64) granted = {granted, alloc_offset};

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Valid stays high after a transfer until the next item or an idle cycle,
  // so the next item can follow without a gap.
  task automatic send_command(cmd_t cmd, logic [31:0] size, logic [4:0] a,
                              logic [31:0] off);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    req_size <= size;
    align_log2 <= a;
    free_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic random_command;
    int pick;
    logic [31:0] sz, off;
    pick = $urandom_range(99);
    if (pick < 50) begin
      sz = $urandom_range(99) < 85 ? $urandom_range(1, 3000) : $urandom;
      send_command(CMD_ALLOC, sz, 5'($urandom_range(99) < 90 ? $urandom_range(0, 8)
                                                             : $urandom_range(0, 31)), 0);
    end else if (pick < 85 && granted.size() > 0) begin
      off = granted[$urandom_range(granted.size() - 1)];
      send_command(CMD_FREE, $urandom_range(1, 2048), 5'($urandom), off);
    end else begin
      send_command(cmd_t'($urandom_range(1)), $urandom_range(99) < 10 ? 0 : $urandom,
                   5'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: seeding, zero sizes, extremes, growth, capacity, top clipping.
    send_command(CMD_ALLOC, 0, 0, 0);
    send_command(CMD_ALLOC, 100, 4, 0);
    send_command(CMD_ALLOC, 5000, 16, 0);
    send_command(CMD_FREE, 100, 0, 0);
    send_command(CMD_FREE, 0, 0, 32'h10);
    send_command(CMD_FREE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_command(CMD_FREE, 32'hFFFF_FFFF, 31, 32'hFFFF_FF00);
    send_command(CMD_ALLOC, 32'hFFFF_FFFF, 31, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 64, 31, 0);
    send_command(CMD_ALLOC, 2000000, 0, 0);
    for (int i = 0; i < 10; i++) send_command(CMD_FREE, 1, 0, 32'h100000 + 4 * i);
    drain();

    write_reg(REG_CHUNK, 1);
    write_reg(REG_MAX_TOTAL, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 1, 0, 0);
    send_command(CMD_ALLOC, 3, 2, 0);
    drain();

    // Fill the table with isolated frees to reach the table-full status.
    for (int i = 0; i < 40; i++) send_command(CMD_FREE, 2, 0, 32'h2000_0000 + 8 * i);
    send_command(CMD_ALLOC, 1, 1, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_CHUNK, 4096);
          write_reg(REG_MAX_TOTAL, 1048576);
        end
        1: begin
          write_reg(REG_CHUNK, 32'hFFFF_FFFF);
          write_reg(REG_MAX_TOTAL, 65536);
        end
        2: begin
          write_reg(REG_CHUNK, 0);
          write_reg(REG_MAX_TOTAL, 1);
        end
        default: begin
          write_reg(REG_CHUNK, $urandom_range(1, 8192));
          write_reg(REG_MAX_TOTAL, $urandom_range(4096, 32'h0100_0000));
        end
      endcase
      for (int i = 0; i < 470; i++) begin
        calm = (phase == 1 && i >= 100 && i < 250);
        if (phase == 0 && i == 200) begin
          fork
            begin
              hold_off = 1;
              repeat (3000) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        random_command();
      end
      calm = 0;
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
